// ===== hw/rtl/tdpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpf_pkg
// shared widths, register map, condition codes and the control store of the
// trial division prime filter sequencer
// ----------------------------------------------------------------------------
package tdpf_pkg;

  localparam int ValueW          = 16;
  localparam int CountW          = 16;
  localparam int ValueWidthDflt  = 16;
  localparam int ApbDataW        = 32;
  localparam int ApbAddrW        = 3;
  localparam int PcW             = 4;

  // register map, index of each register
  localparam logic RegKeepMode = 1'b0;

  // keep_mode codes
  localparam logic KeepPrimes    = 1'b0;
  localparam logic KeepNonPrimes = 1'b1;

  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondNoInput,
    CondBelowTwo,
    CondSquareAbove,
    CondDivBusy,
    CondRemZero,
    CondOutBusy
  } cond_e;

  typedef struct packed {
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           in_ready;
    logic           div_start;
    logic           step_div;
    logic           prime_wr;
    logic           prime_val;
    logic           emit;
  } ctrl_t;

  // program steps
  localparam logic [PcW-1:0] StepIdle     = 4'd0;
  localparam logic [PcW-1:0] StepBelowTwo = 4'd1;
  localparam logic [PcW-1:0] StepSquare   = 4'd2;
  localparam logic [PcW-1:0] StepDivGo    = 4'd3;
  localparam logic [PcW-1:0] StepDivWait  = 4'd4;
  localparam logic [PcW-1:0] StepRemTest  = 4'd5;
  localparam logic [PcW-1:0] StepLoop     = 4'd6;
  localparam logic [PcW-1:0] StepNotPrime = 4'd7;
  localparam logic [PcW-1:0] StepPrime    = 4'd8;
  localparam logic [PcW-1:0] StepEmit     = 4'd9;
  localparam logic [PcW-1:0] StepReturn   = 4'd10;

  function automatic ctrl_t ctrl_rom(logic [PcW-1:0] pc);
    ctrl_t w;
    w = '{cond: CondAlways, target: StepIdle, default: 1'b0};
    case (pc)
      StepIdle: begin
        w.cond     = CondNoInput;
        w.target   = StepIdle;
        w.in_ready = 1'b1;
      end
      StepBelowTwo: begin
        w.cond   = CondBelowTwo;
        w.target = StepNotPrime;
      end
      StepSquare: begin
        w.cond   = CondSquareAbove;
        w.target = StepPrime;
      end
      StepDivGo: begin
        w.cond      = CondNever;
        w.div_start = 1'b1;
      end
      StepDivWait: begin
        w.cond   = CondDivBusy;
        w.target = StepDivWait;
      end
      StepRemTest: begin
        w.cond     = CondRemZero;
        w.target   = StepNotPrime;
        w.step_div = 1'b1;
      end
      StepLoop: begin
        w.cond   = CondAlways;
        w.target = StepSquare;
      end
      StepNotPrime: begin
        w.cond      = CondAlways;
        w.target    = StepEmit;
        w.prime_wr  = 1'b1;
        w.prime_val = 1'b0;
      end
      StepPrime: begin
        w.cond      = CondNever;
        w.prime_wr  = 1'b1;
        w.prime_val = 1'b1;
      end
      StepEmit: begin
        w.cond   = CondOutBusy;
        w.target = StepEmit;
        w.emit   = 1'b1;
      end
      StepReturn: begin
        w.cond   = CondAlways;
        w.target = StepIdle;
      end
      default: begin
        w.cond   = CondAlways;
        w.target = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/tdpf_in_if.sv =====
// ----------------------------------------------------------------------------
// tdpf_in_if
// input channel: one number to classify and its last marker per transfer
// ----------------------------------------------------------------------------
interface tdpf_in_if import tdpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic              in_last;

  modport source (output valid, output value, output in_last, input ready);
  modport sink (input valid, input value, input in_last, output ready);
endinterface

// ===== hw/rtl/tdpf_out_if.sv =====
// ----------------------------------------------------------------------------
// tdpf_out_if
// result channel: classified number, flags and the running prime count
// ----------------------------------------------------------------------------
interface tdpf_out_if import tdpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] out_value;
  logic              is_prime;
  logic              kept;
  logic [CountW-1:0] prime_total;
  logic              out_last;

  modport source (
    output valid, output out_value, output is_prime, output kept,
    output prime_total, output out_last, input ready
  );
  modport sink (
    input valid, input out_value, input is_prime, input kept,
    input prime_total, input out_last, output ready
  );
endinterface

// ===== hw/rtl/tdpf_divider.sv =====
// ----------------------------------------------------------------------------
// tdpf_divider
// restoring divider, one quotient bit per cycle, returns the remainder
// ----------------------------------------------------------------------------
module tdpf_divider import tdpf_pkg::*; #(
  parameter int WIDTH = ValueWidthDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             busy_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int CntW = $clog2(WIDTH + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH:0]   trial;

  assign trial = {rem_q, quo_q[WIDTH-1]};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = CntW'(WIDTH);
      rem_d = '0;
      quo_d = dividend_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = WIDTH'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/trial_division_prime_filter.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_filter
// sequencing: 0 and 1 are classified as not prime without a division; a prime
// runs one division on the restoring divider for each of the k divisors tried,
// k = floor(sqrt(n)) - 1; a composite stops at its first divisor
// one number at a time; a new number is taken while the previous result waits
// reset: asynchronous, clears the sequencer, keep_mode and the prime count
// ----------------------------------------------------------------------------
module trial_division_prime_filter import tdpf_pkg::*; #(
  parameter int VALUE_WIDTH = ValueWidthDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tdpf_in_if.sink             in_if,
  tdpf_out_if.source          out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int NumW = (VALUE_WIDTH < ValueW) ? VALUE_WIDTH : ValueW;
  localparam int SqW  = NumW + 1;
  localparam logic [NumW-1:0] FirstDiv = NumW'(2);
  localparam logic [SqW-1:0]  FirstSq  = SqW'(4);

  // control store
  logic [PcW-1:0] pc_q;
  ctrl_t          cw;
  logic           cond_hit;

  // datapath
  logic [NumW-1:0] n_q, d_q;
  logic [SqW-1:0]  sq_q;
  logic            last_q, prime_q;
  logic            div_busy;
  logic [NumW-1:0] div_rem;

  // result and state
  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_prime_q, out_kept_q, out_last_q;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              keep_mode_q;
  logic              in_xfer, out_xfer, cfg_wr;

  assign cw       = ctrl_rom(pc_q);
  assign in_xfer  = cw.in_ready & in_if.valid;
  assign out_xfer = out_valid_q & out_if.ready;

  always_comb begin
    case (cw.cond)
      CondNever:       cond_hit = 1'b0;
      CondAlways:      cond_hit = 1'b1;
      CondNoInput:     cond_hit = ~in_if.valid;
      CondBelowTwo:    cond_hit = (n_q < FirstDiv);
      CondSquareAbove: cond_hit = (sq_q > {1'b0, n_q});
      CondDivBusy:     cond_hit = div_busy;
      CondRemZero:     cond_hit = (div_rem == '0);
      CondOutBusy:     cond_hit = out_valid_q & ~out_if.ready;
      default:         cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if ((keep_mode_q == KeepPrimes) && prime_q && (cnt_q != '1)) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == RegKeepMode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StepIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      keep_mode_q <= KeepPrimes;
    end else begin
      pc_q <= cond_hit ? cw.target : pc_q + 1'b1;
      if (cw.emit && !cond_hit) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        keep_mode_q <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      n_q    <= in_if.value[NumW-1:0];
      last_q <= in_if.in_last;
      d_q    <= FirstDiv;
      sq_q   <= FirstSq;
    end
    if (cw.step_div) begin
      d_q  <= d_q + 1'b1;
      sq_q <= sq_q + {d_q, 1'b1};
    end
    if (cw.prime_wr) begin
      prime_q <= cw.prime_val;
    end
    if (cw.emit && !cond_hit) begin
      out_value_q <= ValueW'(n_q);
      out_prime_q <= prime_q;
      out_kept_q  <= (keep_mode_q == KeepNonPrimes) ? ~prime_q : prime_q;
      out_last_q  <= last_q;
    end
  end

  tdpf_divider #(
    .WIDTH(NumW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cw.div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  assign in_if.ready        = cw.in_ready;
  assign out_if.valid       = out_valid_q;
  assign out_if.out_value   = out_value_q;
  assign out_if.is_prime    = out_prime_q;
  assign out_if.kept        = out_kept_q;
  assign out_if.prime_total = cnt_q;
  assign out_if.out_last    = out_last_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegKeepMode) ? ApbDataW'(keep_mode_q) : '0;

endmodule
